// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/cwss_pkg.sv
// shared types and constants of the chunk window scheduler
`default_nettype none
package cwss_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD     = 2'd0,
		CMD_BUILD    = 2'd1,
		CMD_UPLOAD   = 2'd2,
		CMD_RECENTER = 2'd3
	} cmd_e_t;

	localparam logic [2:0] ST_PRESENT  = 3'b001;
	localparam logic [2:0] ST_BUILT    = 3'b010;
	localparam logic [2:0] ST_UPLOADED = 3'b100;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SC_RD,
		S_SC_CHK,
		S_RC_RD,
		S_RC_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic cap;
		logic sc_chk;
		logic rc_rd;
		logic rc_wr;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hit;
		logic miss;
		logic scan_end;
		logic rc_last;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/cwss_if.sv
// request and response channel interfaces
`default_nettype none
interface cwss_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [15:0] new_center_x;
	logic signed [15:0] new_center_y;
	logic signed [15:0] new_center_z;
	modport source (output valid, cmd, new_center_x, new_center_y, new_center_z, input ready);
	modport sink (input valid, cmd, new_center_x, new_center_y, new_center_z, output ready);
endinterface

interface cwss_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [15:0] chunk_x;
	logic signed [15:0] chunk_y;
	logic signed [15:0] chunk_z;
	modport source (output valid, found, chunk_x, chunk_y, chunk_z, input ready);
	modport sink (input valid, found, chunk_x, chunk_y, chunk_z, output ready);
endinterface
`default_nettype wire

// File: rtl/chunk_window_spiral_scheduler_unit.sv
// top level of the chunk window spiral scheduler
// usage:
//   req carries one command (load, build, upload or recenter) with the new
//   centre used by recenter; rsp returns one result per command: found and
//   the world chunk coordinates, all zero when nothing was found.
//   commands are handled one at a time; req is ready only when the engine
//   is idle, and a finished result waits in the rsp register so the next
//   command can be taken while it is still unread.
//   load and upload read and then check each slot in spiral order; build
//   reads and checks the slot and its six neighbours one at a time through
//   the single read port of the slot store; recenter reads and then writes
//   each slot, copying between two banks of the slot store; every command
//   ends in a state that hands its result over.
//   after reset the active bank is cleared, one slot a cycle, through all
//   SLOTS slots ((2W+1)^2*(2H+1)) before req goes ready.
//   when rsp is stalled a finished command waits before handing over and
//   no new command is taken until its result is in the rsp register.
`default_nettype none
module chunk_window_spiral_scheduler_unit #(
	parameter int HALF_WIDTH  = 4,
	parameter int HALF_HEIGHT = 2
) (
	input  wire          clk,
	input  wire          arst_n,
	cwss_req_if.sink     req,
	cwss_rsp_if.source   rsp
);
	cwss_pkg::ctl_cmd_t ctl;
	cwss_pkg::dp_stat_t stat;

	cwss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	cwss_datapath #(
		.HALF_WIDTH  (HALF_WIDTH),
		.HALF_HEIGHT (HALF_HEIGHT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.stat    (stat),
		.cmd_in  (req.cmd),
		.ncx_in  (req.new_center_x),
		.ncy_in  (req.new_center_y),
		.ncz_in  (req.new_center_z),
		.found   (rsp.found),
		.chunk_x (rsp.chunk_x),
		.chunk_y (rsp.chunk_y),
		.chunk_z (rsp.chunk_z)
	);
endmodule
`default_nettype wire

// File: rtl/cwss_datapath.sv
// slot store, spiral walker, recenter remap and result registers
`default_nettype none
module cwss_datapath #(
	parameter int HALF_WIDTH  = 4,
	parameter int HALF_HEIGHT = 2
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  cwss_pkg::ctl_cmd_t       ctl,
	output cwss_pkg::dp_stat_t       stat,
	input  wire [1:0]                cmd_in,
	input  wire signed [15:0]        ncx_in,
	input  wire signed [15:0]        ncy_in,
	input  wire signed [15:0]        ncz_in,
	output logic                     found,
	output logic signed [15:0]       chunk_x,
	output logic signed [15:0]       chunk_y,
	output logic signed [15:0]       chunk_z
);
	localparam int SPAN_XZ = 2 * HALF_WIDTH + 1;
	localparam int SPAN_Y  = 2 * HALF_HEIGHT + 1;
	localparam int SLOTS   = SPAN_XZ * SPAN_XZ * SPAN_Y;
	localparam int AW      = $clog2(SLOTS);
	localparam int MAXS    = (SPAN_XZ > SPAN_Y) ? SPAN_XZ : SPAN_Y;
	localparam int CW      = $clog2(MAXS + 1) + 1;

	typedef logic signed [CW-1:0] crd_t;

	localparam crd_t XZ_LAST = crd_t'(SPAN_XZ - 1);
	localparam crd_t Y_LAST  = crd_t'(SPAN_Y - 1);

	function automatic logic [AW-1:0] slot_addr(crd_t x, crd_t y, crd_t z);
		int t;
		t = int'(x) + SPAN_XZ * (int'(y) + SPAN_Y * int'(z));
		return AW'(t);
	endfunction

	function automatic logic in_win(crd_t x, crd_t y, crd_t z);
		return (x >= 0) && (x <= XZ_LAST) && (y >= 0) && (y <= Y_LAST) &&
			(z >= 0) && (z <= XZ_LAST);
	endfunction

	logic [2:0] mem0_q [SLOTS];
	logic [2:0] mem1_q [SLOTS];
	logic [2:0] rdata_q;

	cwss_pkg::cmd_e_t   cmd_q;
	logic signed [15:0] ncx_q, ncy_q, ncz_q;
	logic signed [15:0] cx_q, cy_q, cz_q;
	logic               bank_q;
	logic [AW-1:0]      clr_q;
	crd_t               lox_q, hix_q, loz_q, hiz_q, i_q, y_q;
	logic [1:0]         leg_q;
	logic [2:0]         k_q;
	logic [2:0]         stat_q;
	logic               srcin_q;
	crd_t               rx_q, ry_q, rz_q;
	logic               res_found_q;
	crd_t               fx_q, fy_q, fz_q;

	crd_t          colx, colz, px, py, pz;
	logic          p_in, ok, last_probe, walk_end;
	logic [AW-1:0] probe_addr, src_addr, dst_addr, ra, wa;
	logic [2:0]    wd, hit_val;
	logic          we, wbank;
	logic signed [16:0] dx, dy, dz;
	logic signed [17:0] ox, oy, oz;
	logic          src_in;

	// current column of the spiral
	always_comb begin
		case (leg_q)
			2'd0: begin colx = i_q;   colz = loz_q; end
			2'd1: begin colx = hix_q; colz = i_q;   end
			2'd2: begin colx = i_q;   colz = hiz_q; end
			default: begin colx = lox_q; colz = i_q; end
		endcase
	end

	// probe zero is the slot itself, then its six neighbours
	always_comb begin
		px = colx;
		py = y_q;
		pz = colz;
		case (k_q)
			3'd1: py = y_q + crd_t'(1);
			3'd2: py = y_q - crd_t'(1);
			3'd3: px = colx + crd_t'(1);
			3'd4: px = colx - crd_t'(1);
			3'd5: pz = colz + crd_t'(1);
			3'd6: pz = colz - crd_t'(1);
			default: ;
		endcase
	end

	always_comb begin
		p_in = in_win(px, py, pz);
		probe_addr = p_in ? slot_addr(px, py, pz) : '0;
		if (k_q == 3'd0) begin
			case (cmd_q)
				cwss_pkg::CMD_LOAD:  ok = !rdata_q[0];
				cwss_pkg::CMD_BUILD: ok = rdata_q[0] && !rdata_q[1];
				default:             ok = rdata_q[1] && !rdata_q[2];
			endcase
		end else begin
			ok = !p_in || rdata_q[0];
		end
		last_probe = (cmd_q != cwss_pkg::CMD_BUILD) || (k_q == 3'd6);
		case (leg_q)
			2'd0: walk_end = (i_q == hix_q) && (hix_q == XZ_LAST);
			2'd1: walk_end = (i_q == hiz_q) && (hiz_q == XZ_LAST);
			2'd2: walk_end = (i_q == lox_q) && (lox_q == crd_t'(0));
			default: walk_end = (i_q == loz_q) && (loz_q == crd_t'(0));
		endcase
		case (cmd_q)
			cwss_pkg::CMD_LOAD:  hit_val = cwss_pkg::ST_PRESENT;
			cwss_pkg::CMD_BUILD: hit_val = stat_q | cwss_pkg::ST_BUILT;
			default:             hit_val = rdata_q | cwss_pkg::ST_UPLOADED;
		endcase
	end

	// recenter source slot, compared as plain integers
	always_comb begin
		dx = 17'(ncx_q) - 17'(cx_q);
		dy = 17'(ncy_q) - 17'(cy_q);
		dz = 17'(ncz_q) - 17'(cz_q);
		ox = 18'(rx_q) + 18'(dx);
		oy = 18'(ry_q) + 18'(dy);
		oz = 18'(rz_q) + 18'(dz);
		src_in = (ox >= 0) && (ox < 18'(SPAN_XZ)) && (oy >= 0) && (oy < 18'(SPAN_Y)) &&
			(oz >= 0) && (oz < 18'(SPAN_XZ));
		src_addr = src_in ? slot_addr(crd_t'(ox), crd_t'(oy), crd_t'(oz)) : '0;
		dst_addr = slot_addr(rx_q, ry_q, rz_q);
	end

	assign stat.clr_last = (clr_q == AW'(SLOTS - 1));
	assign stat.hit      = ok && last_probe;
	assign stat.miss     = !ok;
	assign stat.scan_end = (y_q == Y_LAST) && walk_end;
	assign stat.rc_last  = (rx_q == XZ_LAST) && (ry_q == Y_LAST) && (rz_q == XZ_LAST);

	always_comb begin
		ra    = ctl.rc_rd ? src_addr : probe_addr;
		we    = ctl.clr_step || (ctl.sc_chk && stat.hit) || ctl.rc_wr;
		wbank = ctl.rc_wr ? !bank_q : bank_q;
		if (ctl.clr_step) begin
			wa = clr_q;
			wd = '0;
		end else if (ctl.rc_wr) begin
			wa = dst_addr;
			wd = srcin_q ? rdata_q : 3'b000;
		end else begin
			wa = slot_addr(colx, y_q, colz);
			wd = hit_val;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			if (wbank) mem1_q[wa] <= wd;
			else mem0_q[wa] <= wd;
		end
		rdata_q <= bank_q ? mem1_q[ra] : mem0_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			clr_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			cz_q   <= '0;
			cmd_q  <= cwss_pkg::CMD_LOAD;
			lox_q  <= '0;
			hix_q  <= '0;
			loz_q  <= '0;
			hiz_q  <= '0;
			i_q    <= '0;
			leg_q  <= '0;
			y_q    <= '0;
			k_q    <= '0;
			rx_q   <= '0;
			ry_q   <= '0;
			rz_q   <= '0;
			res_found_q <= 1'b0;
		end else begin
			if (ctl.clr_step) clr_q <= clr_q + AW'(1);
			if (ctl.cap) begin
				cmd_q <= cwss_pkg::cmd_e_t'(cmd_in);
				lox_q <= crd_t'(HALF_WIDTH);
				hix_q <= crd_t'(HALF_WIDTH);
				loz_q <= crd_t'(HALF_WIDTH);
				hiz_q <= crd_t'(HALF_WIDTH);
				i_q   <= crd_t'(HALF_WIDTH);
				leg_q <= 2'd0;
				y_q   <= '0;
				k_q   <= '0;
				rx_q  <= '0;
				ry_q  <= '0;
				rz_q  <= '0;
				res_found_q <= 1'b0;
			end
			if (ctl.sc_chk) begin
				if (k_q == 3'd0) stat_q <= rdata_q;
				if (stat.hit) begin
					res_found_q <= 1'b1;
				end else if (stat.miss) begin
					k_q <= '0;
					if (y_q != Y_LAST) begin
						y_q <= y_q + crd_t'(1);
					end else begin
						y_q <= '0;
						case (leg_q)
							2'd0: begin
								if (i_q != hix_q) i_q <= i_q + crd_t'(1);
								else begin hix_q <= hix_q + crd_t'(1); leg_q <= 2'd1; i_q <= loz_q; end
							end
							2'd1: begin
								if (i_q != hiz_q) i_q <= i_q + crd_t'(1);
								else begin hiz_q <= hiz_q + crd_t'(1); leg_q <= 2'd2; i_q <= hix_q; end
							end
							2'd2: begin
								if (i_q != lox_q) i_q <= i_q - crd_t'(1);
								else begin lox_q <= lox_q - crd_t'(1); leg_q <= 2'd3; i_q <= hiz_q; end
							end
							default: begin
								if (i_q != loz_q) i_q <= i_q - crd_t'(1);
								else begin loz_q <= loz_q - crd_t'(1); leg_q <= 2'd0; i_q <= lox_q; end
							end
						endcase
					end
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
			if (ctl.rc_wr) begin
				if (rx_q != XZ_LAST) begin
					rx_q <= rx_q + crd_t'(1);
				end else begin
					rx_q <= '0;
					if (ry_q != Y_LAST) begin
						ry_q <= ry_q + crd_t'(1);
					end else begin
						ry_q <= '0;
						rz_q <= rz_q + crd_t'(1);
					end
				end
				if (stat.rc_last) begin
					bank_q <= !bank_q;
					cx_q   <= ncx_q;
					cy_q   <= ncy_q;
					cz_q   <= ncz_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			ncx_q <= ncx_in;
			ncy_q <= ncy_in;
			ncz_q <= ncz_in;
		end
		if (ctl.rc_rd) srcin_q <= src_in;
		if (ctl.sc_chk && stat.hit) begin
			fx_q <= colx;
			fy_q <= y_q;
			fz_q <= colz;
		end
		if (ctl.out_load) begin
			found <= res_found_q;
			if (res_found_q) begin
				chunk_x <= 16'(cx_q - 16'(HALF_WIDTH) + 16'(fx_q));
				chunk_y <= 16'(cy_q - 16'(HALF_HEIGHT) + 16'(fy_q));
				chunk_z <= 16'(cz_q - 16'(HALF_WIDTH) + 16'(fz_q));
			end else begin
				chunk_x <= '0;
				chunk_y <= '0;
				chunk_z <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/cwss_ctrl.sv
// controller state machine of the chunk window scheduler
`default_nettype none
module cwss_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	input  wire [1:0]           req_cmd,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output cwss_pkg::ctl_cmd_t  ctl,
	input  cwss_pkg::dp_stat_t  stat
);
	cwss_pkg::state_t state_q, state_d;
	logic out_free;

	assign out_free = !rsp_valid || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cwss_pkg::S_CLEAR: if (stat.clr_last) state_d = cwss_pkg::S_IDLE;
			cwss_pkg::S_IDLE: begin
				if (req_valid) begin
					if (cwss_pkg::cmd_e_t'(req_cmd) == cwss_pkg::CMD_RECENTER)
						state_d = cwss_pkg::S_RC_RD;
					else
						state_d = cwss_pkg::S_SC_RD;
				end
			end
			cwss_pkg::S_SC_RD: state_d = cwss_pkg::S_SC_CHK;
			cwss_pkg::S_SC_CHK: begin
				if (stat.hit || (stat.miss && stat.scan_end)) state_d = cwss_pkg::S_FIN;
				else state_d = cwss_pkg::S_SC_RD;
			end
			cwss_pkg::S_RC_RD: state_d = cwss_pkg::S_RC_WR;
			cwss_pkg::S_RC_WR: begin
				if (stat.rc_last) state_d = cwss_pkg::S_FIN;
				else state_d = cwss_pkg::S_RC_RD;
			end
			cwss_pkg::S_FIN: if (out_free) state_d = cwss_pkg::S_IDLE;
			default: state_d = cwss_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		req_ready = 1'b0;
		case (state_q)
			cwss_pkg::S_CLEAR: ctl.clr_step = 1'b1;
			cwss_pkg::S_IDLE: begin
				req_ready = 1'b1;
				ctl.cap   = req_valid;
			end
			cwss_pkg::S_SC_CHK: ctl.sc_chk = 1'b1;
			cwss_pkg::S_RC_RD:  ctl.rc_rd = 1'b1;
			cwss_pkg::S_RC_WR:  ctl.rc_wr = 1'b1;
			cwss_pkg::S_FIN:    ctl.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cwss_pkg::S_CLEAR;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) rsp_valid <= 1'b1;
			else if (rsp_ready) rsp_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: rtl/cwss_checker.sv
// port-level checker of the chunk window scheduler and its bind
`default_nettype none
`include "assert_macros.svh"
module cwss_port_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               req_valid,
	input wire               req_ready,
	input wire [1:0]         req_cmd,
	input wire               rsp_valid,
	input wire               rsp_ready,
	input wire               rsp_found,
	input wire signed [15:0] rsp_chunk_x,
	input wire signed [15:0] rsp_chunk_y,
	input wire signed [15:0] rsp_chunk_z
);
	logic last_rc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rc_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			last_rc_q <= (cwss_pkg::cmd_e_t'(req_cmd) == cwss_pkg::CMD_RECENTER);
		end
	end

	// a stalled result holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_chunk_x) && $stable(rsp_chunk_y) && $stable(rsp_chunk_z))
	// nothing found reports zero coordinates
	`ASSERT_IMPL(a_zero_coords, clk, arst_n, rsp_valid && !rsp_found, rsp_chunk_x == 16'sd0 && rsp_chunk_y == 16'sd0 && rsp_chunk_z == 16'sd0)
	// a fresh result after a recenter transfer never reports found
	`ASSERT_IMPL(a_rc_not_found, clk, arst_n, $rose(rsp_valid) && last_rc_q, !rsp_found)
endmodule

bind chunk_window_spiral_scheduler_unit cwss_port_checker u_cwss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_cmd     (req.cmd),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_found   (rsp.found),
	.rsp_chunk_x (rsp.chunk_x),
	.rsp_chunk_y (rsp.chunk_y),
	.rsp_chunk_z (rsp.chunk_z)
);
`default_nettype wire

// File: sim/cwss_checker.sv
// checker: predicts each scheduler result and compares it with the response channel
`timescale 1ns / 1ps
`default_nettype none
module cwss_checker #(
	parameter int HALF_WIDTH  = 4,
	parameter int HALF_HEIGHT = 2
) (
	input  wire  clk,
	input  wire  arst_n,
	cwss_req_if  req,
	cwss_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);

	localparam int SPAN_XZ = 2 * HALF_WIDTH + 1;
	localparam int SPAN_Y  = 2 * HALF_HEIGHT + 1;
	localparam int SLOTS   = SPAN_XZ * SPAN_XZ * SPAN_Y;

	typedef struct packed {
		logic               found;
		logic signed [15:0] chunk_x;
		logic signed [15:0] chunk_y;
		logic signed [15:0] chunk_z;
	} chunk_result_t;

	logic [2:0]    slot_bits [SLOTS];
	logic [2:0]    remap_bits [SLOTS];
	int            cen_x, cen_y, cen_z;
	chunk_result_t result_q [$];

	function automatic int slot_at(int x, int y, int z);
		return x + SPAN_XZ * (y + SPAN_Y * z);
	endfunction

	function automatic bit present_or_outside(int x, int y, int z);
		if (x < 0 || x >= SPAN_XZ || y < 0 || y >= SPAN_Y || z < 0 || z >= SPAN_XZ)
			return 1'b1;
		return slot_bits[slot_at(x, y, z)][0];
	endfunction

	// bottom-to-top scan of one column, marks the first qualifying slot
	function automatic bit scan_column(cwss_pkg::cmd_e_t mode, int x, int z, output int fy);
		logic [2:0] s;
		int i;
		fy = -1;
		for (int y = 0; y < SPAN_Y; y++) begin
			i = slot_at(x, y, z);
			s = slot_bits[i];
			if (mode == cwss_pkg::CMD_LOAD) begin
				if (!(s & cwss_pkg::ST_PRESENT)) begin
					slot_bits[i] = cwss_pkg::ST_PRESENT;
					fy = y;
					return 1'b1;
				end
			end else if (mode == cwss_pkg::CMD_BUILD) begin
				if ((s & cwss_pkg::ST_PRESENT) && !(s & cwss_pkg::ST_BUILT) &&
				    present_or_outside(x, y + 1, z) && present_or_outside(x, y - 1, z) &&
				    present_or_outside(x + 1, y, z) && present_or_outside(x - 1, y, z) &&
				    present_or_outside(x, y, z + 1) && present_or_outside(x, y, z - 1)) begin
					slot_bits[i] = s | cwss_pkg::ST_BUILT;
					fy = y;
					return 1'b1;
				end
			end else begin
				if ((s & cwss_pkg::ST_BUILT) && !(s & cwss_pkg::ST_UPLOADED)) begin
					slot_bits[i] = s | cwss_pkg::ST_UPLOADED;
					fy = y;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic bit spiral_pick(cwss_pkg::cmd_e_t mode, output int fx, output int fy,
	                                   output int fz);
		int lox, hix, loz, hiz;
		lox = HALF_WIDTH; hix = HALF_WIDTH; loz = HALF_WIDTH; hiz = HALF_WIDTH;
		fx = 0; fy = 0; fz = 0;
		while (lox >= 0 && hix < SPAN_XZ && loz >= 0 && hiz < SPAN_XZ) begin
			for (int i = lox; i <= hix; i++)
				if (scan_column(mode, i, loz, fy)) begin
					fx = i; fz = loz; return 1'b1;
				end
			hix++;
			if (hix >= SPAN_XZ) continue;
			for (int i = loz; i <= hiz; i++)
				if (scan_column(mode, hix, i, fy)) begin
					fx = hix; fz = i; return 1'b1;
				end
			hiz++;
			if (hiz >= SPAN_XZ) continue;
			for (int i = hix; i >= lox; i--)
				if (scan_column(mode, i, hiz, fy)) begin
					fx = i; fz = hiz; return 1'b1;
				end
			lox--;
			if (lox < 0) continue;
			for (int i = hiz; i >= loz; i--)
				if (scan_column(mode, lox, i, fy)) begin
					fx = lox; fz = i; return 1'b1;
				end
			loz--;
		end
		return 1'b0;
	endfunction

	// plain integer compare of centres, no wrap across the 16-bit edge
	function automatic void shift_window(int nx, int ny, int nz);
		int ox, oy, oz;
		for (int z = 0; z < SPAN_XZ; z++)
			for (int y = 0; y < SPAN_Y; y++)
				for (int x = 0; x < SPAN_XZ; x++) begin
					ox = x + nx - cen_x;
					oy = y + ny - cen_y;
					oz = z + nz - cen_z;
					if (ox >= 0 && ox < SPAN_XZ && oy >= 0 && oy < SPAN_Y &&
					    oz >= 0 && oz < SPAN_XZ)
						remap_bits[slot_at(x, y, z)] = slot_bits[slot_at(ox, oy, oz)];
					else
						remap_bits[slot_at(x, y, z)] = '0;
				end
		slot_bits = remap_bits;
		cen_x = nx; cen_y = ny; cen_z = nz;
	endfunction

	function automatic chunk_result_t predict_chunk(cwss_pkg::cmd_e_t c,
	                                                logic signed [15:0] nx,
	                                                logic signed [15:0] ny,
	                                                logic signed [15:0] nz);
		chunk_result_t r;
		int fx, fy, fz;
		r = '0;
		if (c == cwss_pkg::CMD_RECENTER) begin
			shift_window(int'(nx), int'(ny), int'(nz));
		end else if (spiral_pick(c, fx, fy, fz)) begin
			r.found   = 1'b1;
			r.chunk_x = 16'(cen_x - HALF_WIDTH + fx);
			r.chunk_y = 16'(cen_y - HALF_HEIGHT + fy);
			r.chunk_z = 16'(cen_z - HALF_WIDTH + fz);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chunk_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) slot_bits[i] = '0;
			cen_x = 0; cen_y = 0; cen_z = 0;
			result_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected transfer found=%0b x=%0d y=%0d z=%0d", $time,
					         rsp.found, rsp.chunk_x, rsp.chunk_y, rsp.chunk_z);
					fail_count <= fail_count + 1;
				end else begin
					e = result_q.pop_front();
					if (e.found !== rsp.found || e.chunk_x !== rsp.chunk_x ||
					    e.chunk_y !== rsp.chunk_y || e.chunk_z !== rsp.chunk_z) begin
						$display("%0t: expected found=%0b x=%0d y=%0d z=%0d, got found=%0b x=%0d y=%0d z=%0d",
						         $time, e.found, e.chunk_x, e.chunk_y, e.chunk_z,
						         rsp.found, rsp.chunk_x, rsp.chunk_y, rsp.chunk_z);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req.valid && req.ready)
				result_q.push_back(predict_chunk(cwss_pkg::cmd_e_t'(req.cmd),
				                                 req.new_center_x, req.new_center_y,
				                                 req.new_center_z));
			pending <= result_q.size();
		end
	end

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// testbench top: stimulus, response back-pressure and verdict for the scheduler
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int  N_RANDOM = 1200;
	localparam longint LIMIT = 40_000_000;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	int     fail_count, pending;
	longint cycles = 0;
	bit     long_hold = 1'b0;
	int     cx = 0, cy = 0, cz = 0;

	cwss_req_if req ();
	cwss_rsp_if rsp ();

	chunk_window_spiral_scheduler_unit u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	cwss_checker u_chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
	                    .fail_count(fail_count), .pending(pending));

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
		return $urandom_range(10, 80);
	endfunction

	// offer one command, hold it until the transfer, then drop valid for the gap if nonzero
	task automatic send_cmd(cwss_pkg::cmd_e_t c, int nx, int ny, int nz, int gap);
		req.valid        <= 1'b1;
		req.cmd          <= c;
		req.new_center_x <= 16'(nx);
		req.new_center_y <= 16'(ny);
		req.new_center_z <= 16'(nz);
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
		if (c == cwss_pkg::CMD_RECENTER) begin
			cx = int'($signed(16'(nx)));
			cy = int'($signed(16'(ny)));
			cz = int'($signed(16'(nz)));
		end
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(int gap);
		int r, k;
		r = $urandom_range(0, 99);
		if (r < 38) send_cmd(cwss_pkg::CMD_LOAD, $urandom, $urandom, $urandom, gap);
		else if (r < 68) send_cmd(cwss_pkg::CMD_BUILD, $urandom, $urandom, $urandom, gap);
		else if (r < 88) send_cmd(cwss_pkg::CMD_UPLOAD, $urandom, $urandom, $urandom, gap);
		else begin
			k = $urandom_range(0, 9);
			if (k < 8)
				send_cmd(cwss_pkg::CMD_RECENTER, cx + $urandom_range(0, 4) - 2,
				         cy + $urandom_range(0, 4) - 2, cz + $urandom_range(0, 4) - 2, gap);
			else if (k == 8)
				send_cmd(cwss_pkg::CMD_RECENTER, $urandom, $urandom, $urandom, gap);
			else
				send_cmd(cwss_pkg::CMD_RECENTER, 32767 - $urandom_range(0, 6),
				         -32768 + $urandom_range(0, 6), 32767 - $urandom_range(0, 6), gap);
		end
	endtask

	// receiver: bursts of ready and stall, one long hold-off on request
	initial begin
		int n;
		bit lvl;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				rsp.ready <= 1'b0;
				repeat (4000) @(posedge clk);
			end
			lvl = ($urandom_range(0, 9) < 7);
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 200);
			rsp.ready <= lvl;
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		bit nogap;
		req.valid        <= 1'b0;
		req.cmd          <= cwss_pkg::CMD_LOAD;
		req.new_center_x <= '0;
		req.new_center_y <= '0;
		req.new_center_z <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty window: nothing to build or upload
		send_cmd(cwss_pkg::CMD_BUILD, 0, 0, 0, 1);
		send_cmd(cwss_pkg::CMD_UPLOAD, -1, -1, -1, 0);
		send_cmd(cwss_pkg::CMD_LOAD, 0, 0, 0, 0);
		send_cmd(cwss_pkg::CMD_LOAD, 0, 0, 0, 2);
		send_cmd(cwss_pkg::CMD_BUILD, 0, 0, 0, 0);
		// small shift keeps part of the window
		send_cmd(cwss_pkg::CMD_RECENTER, 1, 0, -1, 0);
		send_cmd(cwss_pkg::CMD_LOAD, 0, 0, 0, 0);
		// recenter to the top edge of the coordinate range, then load twice
		send_cmd(cwss_pkg::CMD_RECENTER, 32767, 32767, 32767, 3);
		send_cmd(cwss_pkg::CMD_LOAD, 0, 0, 0, 0);
		send_cmd(cwss_pkg::CMD_LOAD, 0, 0, 0, 0);
		// jump across the edge is not continuous
		send_cmd(cwss_pkg::CMD_RECENTER, -32768, -32768, -32768, 0);
		send_cmd(cwss_pkg::CMD_LOAD, 0, 0, 0, 0);
		send_cmd(cwss_pkg::CMD_UPLOAD, 0, 0, 0, 0);
		send_cmd(cwss_pkg::CMD_RECENTER, -32766, 32765, -1, 0);
		send_cmd(cwss_pkg::CMD_RECENTER, 0, 0, 0, 0);
		send_cmd(cwss_pkg::CMD_LOAD, 0, 0, 0, 0);

		nogap = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0) nogap = ($urandom_range(0, 3) == 0);
			if (i == 500) long_hold = 1'b1;
			if (i == 800) begin
				req.valid <= 1'b0;
				// let the checker count the last transfer first
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_random(nogap ? 0 : pick_gap());
		end
		req.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

// File: chunk_window_spiral_scheduler_unit.f
+incdir+rtl
rtl/cwss_pkg.sv
rtl/cwss_if.sv
rtl/cwss_datapath.sv
rtl/cwss_ctrl.sv
rtl/chunk_window_spiral_scheduler_unit.sv
rtl/cwss_checker.sv
sim/cwss_checker.sv
sim/tb_top.sv
